// ===== design/tevq_pkg.sv =====
// tevq_pkg: shared constants, command codes and slot record for the timed event queue
// used by tevq_slot_store, tevq_order_store and timed_event_queue
`timescale 1ns / 1ps
`default_nettype none

package tevq_pkg;

  localparam int MAX_EVENTS = 32;
  localparam int IDX_W      = $clog2(MAX_EVENTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ID_W       = 5;

  typedef enum logic [2:0] {
    CMD_SET_ABS   = 3'd0,
    CMD_SET_REL   = 3'd1,
    CMD_CANCEL    = 3'd2,
    CMD_REPEAT    = 3'd3,
    CMD_PROGRESS  = 3'd4,
    CMD_QUERY     = 3'd5,
    CMD_FORCE_END = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [31:0] countdown;
    logic [31:0] period;
    logic        notify;
  } slot_t;

endpackage

`default_nettype wire

// ===== design/tevq_slot_store.sv =====
// tevq_slot_store: per-event record memory (countdown, period, notify)
// entries never written read as zero; depends on tevq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tevq_slot_store (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rd_en,
  input  wire logic [tevq_pkg::IDX_W-1:0]   rd_addr,
  output tevq_pkg::slot_t                   rd_data,
  input  wire logic                         wr_en,
  input  wire logic [tevq_pkg::IDX_W-1:0]   wr_addr,
  input  wire tevq_pkg::slot_t              wr_data
);

  tevq_pkg::slot_t                     mem [tevq_pkg::MAX_EVENTS];
  logic [tevq_pkg::MAX_EVENTS-1:0]     written;
  tevq_pkg::slot_t                     rd_q;
  logic                                rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

`default_nettype wire

// ===== design/tevq_order_store.sv =====
// tevq_order_store: two banks of the ordered event list, read from the live bank
// and rebuilt into the other one; depends on tevq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tevq_order_store (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         flip,
  input  wire logic                         rd_en,
  input  wire logic [tevq_pkg::IDX_W-1:0]   rd_idx,
  output logic      [tevq_pkg::IDX_W-1:0]   rd_data,
  input  wire logic                         wr_en,
  input  wire logic [tevq_pkg::IDX_W-1:0]   wr_idx,
  input  wire logic [tevq_pkg::IDX_W-1:0]   wr_data
);

  logic [tevq_pkg::IDX_W-1:0] mem [2*tevq_pkg::MAX_EVENTS];
  logic                       bank;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{~bank, wr_idx}] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[{bank, rd_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
    end else if (flip) begin
      bank <= ~bank;
    end
  end

endmodule

`default_nettype wire

// ===== design/timed_event_queue.sv =====
// timed_event_queue: top level, command sequencer and output register
// depends on tevq_pkg, tevq_slot_store and tevq_order_store
`timescale 1ns / 1ps
`default_nettype none

// A request is one command on the slave stream (cmd in tuser). Every request yields one
// result, except progress, which yields one result per reported expired event (at least
// one); m_tlast marks the final one. The pending list lives in a two-bank memory that is
// rebuilt entry by entry, and event records sit in a second memory with registered reads.
// A new request is accepted only once the previous one is finished. Set, repeat, cancel of
// a pending event and progress walk the whole pending list; query, force, cancel of an idle
// event and unknown codes do not. The list walk, one memory read pair per entry, sets the
// pace. No clearing pass follows reset.

module timed_event_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [30:0]   cfg_wdata,     // max_slice
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [71:0]   s_tdata,       // event_id, event_clock, has_handler, rem_clock
  input  wire logic [2:0]    s_tuser,       // cmd
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [167:0]       m_tdata,       // fired_id, active, remaining, elapsed,
                                            // slice_length, rem_clock_out, total_clock
  output logic               m_tuser,       // fired_valid
  output logic               m_tlast
);

  localparam int IW = tevq_pkg::IDX_W;
  localparam int CW = tevq_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_SCH_CALC, ST_LIST_RD, ST_LIST_CHK, ST_LIST_CMP, ST_LIST_PUT,
    ST_MERGE_END, ST_PRG_RD, ST_PRG_GET, ST_PRG_UPD, ST_PRG_END, ST_PRG_ERD, ST_PRG_EOUT,
    ST_QRY_CALC, ST_EMIT
  } state_t;

  state_t state, state_next;

  logic [2:0]                    cmd;
  logic [tevq_pkg::ID_W-1:0]     id;
  logic [31:0]                   ec, rem;
  logic                          hh;
  logic [30:0]                   max_slice;
  logic [31:0]                   slice, slice_next, acc, acc_next, rem_next;
  logic [CW-1:0]                 cnt, cnt_next, r, r_next, w, w_next, nf, nf_next, k, k_next;
  logic [tevq_pkg::MAX_EVENTS-1:0] pend, pend_next;
  tevq_pkg::slot_t               newrec, newrec_next;
  logic                          allow, allow_next, ins, ins_next;
  logic [IW-1:0]                 x, x_next;
  logic [31:0]                   nb, nb_next;
  logic                          act, act_next;
  logic [31:0]                   remn, remn_next, elap, elap_next;

  logic                          out_load, out_fv, out_last;
  logic [IW-1:0]                 out_fid;
  logic                          out_free;

  logic                          slot_rd_en, slot_wr_en;
  logic [IW-1:0]                 slot_rd_addr, slot_wr_addr;
  tevq_pkg::slot_t               slot_rd_data, slot_wr_data;
  logic                          ord_rd_en, ord_wr_en, ord_flip;
  logic [IW-1:0]                 ord_rd_idx, ord_wr_idx, ord_wr_data, ord_rd_data;

  logic [IW-1:0]                 id_a;
  logic                          valid_id;
  logic [31:0]                   clk_now, cut, nc;
  logic                          ins_f;
  logic [CW-1:0]                 w_f;

  tevq_slot_store u_slot (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data)
  );

  tevq_order_store u_order (
    .clk     (clk),
    .rst     (rst),
    .flip    (ord_flip),
    .rd_en   (ord_rd_en),
    .rd_idx  (ord_rd_idx),
    .rd_data (ord_rd_data),
    .wr_en   (ord_wr_en),
    .wr_idx  (ord_wr_idx),
    .wr_data (ord_wr_data)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign id_a     = IW'(id);
  assign valid_id = CW'(id) < CW'(tevq_pkg::MAX_EVENTS);
  assign clk_now  = slice - rem;

  always_comb begin
    state_next   = state;
    slice_next   = slice;
    acc_next     = acc;
    rem_next     = rem;
    cnt_next     = cnt;
    r_next       = r;
    w_next       = w;
    nf_next      = nf;
    k_next       = k;
    pend_next    = pend;
    newrec_next  = newrec;
    allow_next   = allow;
    ins_next     = ins;
    x_next       = x;
    nb_next      = nb;
    act_next     = act;
    remn_next    = remn;
    elap_next    = elap;
    out_load     = 1'b0;
    out_fv       = 1'b0;
    out_last     = 1'b1;
    out_fid      = '0;
    slot_rd_en   = 1'b0;
    slot_rd_addr = id_a;
    slot_wr_en   = 1'b0;
    slot_wr_addr = id_a;
    slot_wr_data = newrec;
    ord_rd_en    = 1'b0;
    ord_rd_idx   = r[IW-1:0];
    ord_wr_en    = 1'b0;
    ord_wr_idx   = w[IW-1:0];
    ord_wr_data  = id_a;
    ord_flip     = 1'b0;
    cut          = slice;
    nc           = slot_rd_data.countdown - slice;
    ins_f        = ins;
    w_f          = w;

    if ($signed(newrec.countdown) > 0) begin
      cut = slice - newrec.countdown;
    end

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        act_next   = 1'b0;
        remn_next  = '0;
        elap_next  = '0;
        state_next = ST_EMIT;
        case (cmd)
          tevq_pkg::CMD_SET_ABS, tevq_pkg::CMD_SET_REL, tevq_pkg::CMD_REPEAT: begin
            if (valid_id) begin
              slot_rd_en = 1'b1;
              state_next = ST_SCH_CALC;
            end
          end
          tevq_pkg::CMD_CANCEL: begin
            if (valid_id && pend[id_a]) begin
              allow_next = 1'b0;
              ins_next   = 1'b0;
              r_next     = '0;
              w_next     = '0;
              state_next = ST_LIST_RD;
            end
          end
          tevq_pkg::CMD_PROGRESS: begin
            acc_next   = acc + slice;
            nb_next    = {1'b0, max_slice};
            r_next     = '0;
            w_next     = '0;
            nf_next    = '0;
            state_next = ST_PRG_RD;
          end
          tevq_pkg::CMD_QUERY: begin
            if (valid_id && pend[id_a]) begin
              slot_rd_en = 1'b1;
              state_next = ST_QRY_CALC;
            end else begin
              remn_next = '1;
              elap_next = '1;
            end
          end
          tevq_pkg::CMD_FORCE_END: begin
            if ($signed(rem) > 0) begin
              slice_next = slice - rem;
              rem_next   = '0;
            end
          end
          default: begin
            state_next = ST_EMIT;
          end
        endcase
      end

      ST_SCH_CALC: begin
        if (cmd == tevq_pkg::CMD_REPEAT) begin
          newrec_next.period = slot_rd_data.period;
          newrec_next.notify = slot_rd_data.notify;
        end else begin
          newrec_next.period = ec;
          newrec_next.notify = hh;
        end
        if (cmd == tevq_pkg::CMD_SET_ABS) begin
          newrec_next.countdown = ec + clk_now;
        end else begin
          newrec_next.countdown = slot_rd_data.countdown + newrec_next.period;
        end
        slot_wr_en   = 1'b1;
        slot_wr_data = newrec_next;
        allow_next   = (cnt - CW'(pend[id_a])) < CW'(tevq_pkg::MAX_EVENTS);
        ins_next     = 1'b0;
        r_next       = '0;
        w_next       = '0;
        state_next   = ST_LIST_RD;
      end

      ST_LIST_RD: begin
        if (r == cnt) begin
          state_next = ST_MERGE_END;
        end else begin
          ord_rd_en  = 1'b1;
          state_next = ST_LIST_CHK;
        end
      end

      ST_LIST_CHK: begin
        x_next = ord_rd_data;
        if (ord_rd_data == id_a) begin
          r_next     = r + 1'b1;
          state_next = ST_LIST_RD;
        end else begin
          slot_rd_en   = 1'b1;
          slot_rd_addr = ord_rd_data;
          state_next   = ST_LIST_CMP;
        end
      end

      ST_LIST_CMP: begin
        ord_wr_en = 1'b1;
        w_next    = w + 1'b1;
        if (allow && !ins && $signed(newrec.countdown) < $signed(slot_rd_data.countdown)) begin
          ins_next   = 1'b1;
          state_next = ST_LIST_PUT;
          if (w == '0) begin
            slice_next = slice - cut;
            rem_next   = rem - cut;
          end
        end else begin
          ord_wr_data = x;
          r_next      = r + 1'b1;
          state_next  = ST_LIST_RD;
        end
      end

      ST_LIST_PUT: begin
        ord_wr_en   = 1'b1;
        ord_wr_data = x;
        w_next      = w + 1'b1;
        r_next      = r + 1'b1;
        state_next  = ST_LIST_RD;
      end

      ST_MERGE_END: begin
        if (allow && !ins) begin
          ord_wr_en = 1'b1;
          ins_f     = 1'b1;
          w_f       = w + 1'b1;
          if (w == '0) begin
            slice_next = slice - cut;
            rem_next   = rem - cut;
          end
        end
        cnt_next        = w_f;
        pend_next[id_a] = ins_f;
        ord_flip        = 1'b1;
        state_next      = ST_EMIT;
      end

      ST_PRG_RD: begin
        if (r == cnt) begin
          state_next = ST_PRG_END;
        end else begin
          ord_rd_en  = 1'b1;
          state_next = ST_PRG_GET;
        end
      end

      ST_PRG_GET: begin
        x_next       = ord_rd_data;
        slot_rd_en   = 1'b1;
        slot_rd_addr = ord_rd_data;
        state_next   = ST_PRG_UPD;
      end

      ST_PRG_UPD: begin
        slot_wr_en             = 1'b1;
        slot_wr_addr           = x;
        slot_wr_data           = slot_rd_data;
        slot_wr_data.countdown = nc;
        ord_wr_data            = x;
        if ($signed(nc) > 0) begin
          ord_wr_en = 1'b1;
          w_next    = w + 1'b1;
          if ($signed(nb) >= $signed(nc)) begin
            nb_next = nc;
          end
        end else begin
          pend_next[x] = 1'b0;
          if (slot_rd_data.notify) begin
            ord_wr_en  = 1'b1;
            ord_wr_idx = IW'(CW'(tevq_pkg::MAX_EVENTS - 1) - nf);
            nf_next    = nf + 1'b1;
          end
        end
        r_next     = r + 1'b1;
        state_next = ST_PRG_RD;
      end

      ST_PRG_END: begin
        cnt_next   = w;
        slice_next = nb;
        rem_next   = rem + nb;
        ord_flip   = 1'b1;
        k_next     = '0;
        state_next = (nf == '0) ? ST_EMIT : ST_PRG_ERD;
      end

      ST_PRG_ERD: begin
        ord_rd_en  = 1'b1;
        ord_rd_idx = IW'(CW'(tevq_pkg::MAX_EVENTS - 1) - k);
        state_next = ST_PRG_EOUT;
      end

      ST_PRG_EOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_fv   = 1'b1;
          out_fid  = ord_rd_data;
          out_last = (k + 1'b1 == nf);
          k_next   = k + 1'b1;
          state_next = out_last ? ST_IDLE : ST_PRG_ERD;
        end
      end

      ST_QRY_CALC: begin
        act_next   = 1'b1;
        remn_next  = slot_rd_data.countdown - clk_now;
        elap_next  = slot_rd_data.period - remn_next;
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      max_slice <= 31'd1024;
      slice     <= '0;
      acc       <= '0;
      cnt       <= '0;
      pend      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      slice <= slice_next;
      acc   <= acc_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      if (cfg_we) begin
        max_slice <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      cmd <= s_tuser;
      id  <= s_tdata[4:0];
      ec  <= s_tdata[36:5];
      hh  <= s_tdata[37];
      rem <= s_tdata[69:38];
    end else begin
      rem <= rem_next;
    end
    r      <= r_next;
    w      <= w_next;
    nf     <= nf_next;
    k      <= k_next;
    newrec <= newrec_next;
    allow  <= allow_next;
    ins    <= ins_next;
    x      <= x_next;
    nb     <= nb_next;
    act    <= act_next;
    remn   <= remn_next;
    elap   <= elap_next;
    if (out_load) begin
      m_tdata <= {2'b00, acc, rem, slice, elap, remn, act,
                  tevq_pkg::ID_W'(out_fid)};
      m_tuser <= out_fv;
      m_tlast <= out_last;
    end
  end

endmodule

`default_nettype wire

// ===== verif/timed_event_queue_tb.sv =====
// timed_event_queue_tb: self-checking bench for the timed event queue
// depends on tevq_pkg and timed_event_queue; a built-in queue predictor checks every result
`timescale 1ns / 1ps
`default_nettype none

module timed_event_queue_tb;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 6000;

  typedef struct {
    logic [4:0]  fired_id;
    logic        fired_valid;
    logic        last;
    logic        active;
    logic [31:0] remaining;
    logic [31:0] elapsed;
    logic [31:0] slice_length;
    logic [31:0] rem_out;
    logic [31:0] total;
  } fire_report_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [30:0]   cfg_wdata = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [71:0]   s_tdata = '0;   // event_id, event_clock, has_handler, rem_clock
  logic [2:0]    s_tuser = '0;   // cmd
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [167:0]  m_tdata;        // fired_id, active, remaining, elapsed,
                                 // slice_length, rem_clock_out, total_clock
  logic          m_tuser;        // fired_valid
  logic          m_tlast;

  timed_event_queue dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [31:0] q_max_slice = 32'd1024;
  logic [4:0]  q_order [tevq_pkg::MAX_EVENTS];
  int          q_count = 0;
  logic [31:0] q_countdown [tevq_pkg::MAX_EVENTS];
  logic [31:0] q_period [tevq_pkg::MAX_EVENTS];
  logic        q_notify [tevq_pkg::MAX_EVENTS];
  logic [31:0] q_slice = '0;
  logic [31:0] q_total = '0;

  fire_report_t pending_reports[$];
  int errors = 0;
  int checked = 0;
  int fired_seen = 0;
  int requests = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int cycle = 0;

  initial begin
    for (int i = 0; i < tevq_pkg::MAX_EVENTS; i++) begin
      q_order[i] = '0;
      q_countdown[i] = '0;
      q_period[i] = '0;
      q_notify[i] = 1'b0;
    end
  end

  function automatic int find_slot(logic [4:0] id);
    for (int i = 0; i < q_count; i++)
      if (q_order[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_slot(logic [4:0] id);
    int p;
    p = find_slot(id);
    if (p >= 0) begin
      q_count--;
      for (int i = p; i < q_count; i++) q_order[i] = q_order[i + 1];
    end
  endfunction

  function automatic logic [31:0] insert_event(logic [4:0] id, logic [31:0] ec, logic hh,
                                                bit absolute, logic [31:0] rem);
    logic [31:0] elapsed_now;
    logic [31:0] c;
    int e;
    elapsed_now = q_slice - rem;
    q_period[id] = ec;
    q_notify[id] = hh;
    if (absolute) q_countdown[id] = ec + elapsed_now;
    else q_countdown[id] = q_countdown[id] + ec;
    drop_slot(id);
    e = 0;
    while (e < q_count && !($signed(q_countdown[id]) < $signed(q_countdown[q_order[e]])))
      e++;
    if (q_count >= tevq_pkg::MAX_EVENTS) return rem;
    for (int i = q_count; i > e; i--) q_order[i] = q_order[i - 1];
    q_order[e] = id;
    q_count++;
    if (e == 0) begin
      c = q_slice;
      if ($signed(q_countdown[id]) > 0) c = c - q_countdown[id];
      q_slice = q_slice - c;
      rem = rem - c;
    end
    return rem;
  endfunction

  function automatic void push_report(logic [4:0] fid, logic fv, logic act,
                                      logic [31:0] remn, logic [31:0] elap, logic [31:0] rem);
    fire_report_t r;
    r.fired_id = fid;
    r.fired_valid = fv;
    r.last = 1'b1;
    r.active = act;
    r.remaining = remn;
    r.elapsed = elap;
    r.slice_length = q_slice;
    r.rem_out = rem;
    r.total = q_total;
    pending_reports.push_back(r);
  endfunction

  function automatic void predict_queue(logic [2:0] cmd, logic [4:0] id, logic [31:0] ec,
                                        logic hh, logic [31:0] rem);
    logic [4:0]  fired [tevq_pkg::MAX_EVENTS];
    logic [31:0] nb, remn, elap;
    logic [4:0]  cur;
    int nfired, n, k;
    case (cmd)
      tevq_pkg::CMD_SET_ABS: rem = insert_event(id, ec, hh, 1'b1, rem);
      tevq_pkg::CMD_SET_REL: rem = insert_event(id, ec, hh, 1'b0, rem);
      tevq_pkg::CMD_CANCEL: drop_slot(id);
      tevq_pkg::CMD_REPEAT: rem = insert_event(id, q_period[id], q_notify[id], 1'b0, rem);
      tevq_pkg::CMD_PROGRESS: begin
        nfired = 0;
        n = 0;
        k = 0;
        nb = q_max_slice;
        q_total = q_total + q_slice;
        for (int i = 0; i < q_count; i++) begin
          cur = q_order[i];
          q_countdown[cur] = q_countdown[cur] - q_slice;
          if ($signed(q_countdown[cur]) > 0) begin
            q_order[n++] = cur;
            if ($signed(nb) >= $signed(q_countdown[cur])) nb = q_countdown[cur];
          end else begin
            fired[nfired++] = cur;
          end
        end
        q_count = n;
        q_slice = nb;
        rem = rem + nb;
        for (int i = 0; i < nfired; i++)
          if (q_notify[fired[i]]) begin
            if (k > 0) pending_reports[$].last = 1'b0;
            push_report(fired[i], 1'b1, 1'b0, '0, '0, rem);
            k++;
          end
        if (k == 0) push_report('0, 1'b0, 1'b0, '0, '0, rem);
        return;
      end
      tevq_pkg::CMD_QUERY: begin
        if (find_slot(id) >= 0) begin
          remn = q_countdown[id] - (q_slice - rem);
          elap = q_period[id] - remn;
          push_report('0, 1'b0, 1'b1, remn, elap, rem);
        end else begin
          push_report('0, 1'b0, 1'b0, '1, '1, rem);
        end
        return;
      end
      tevq_pkg::CMD_FORCE_END: begin
        if ($signed(rem) > 0) begin
          q_slice = q_slice - rem;
          rem = '0;
        end
      end
      default: ;
    endcase
    push_report('0, 1'b0, 1'b0, '0, '0, rem);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch at result %0d: %s got %h expected %h", checked, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    fire_report_t r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result", {31'd0, m_tvalid}, 32'd0);
      end else begin
        r = pending_reports.pop_front();
        if (m_tdata[4:0] != r.fired_id)
          report_mismatch("fired_id", 32'(m_tdata[4:0]), 32'(r.fired_id));
        if (m_tuser != r.fired_valid)
          report_mismatch("fired_valid", 32'(m_tuser), 32'(r.fired_valid));
        if (m_tlast != r.last) report_mismatch("last", 32'(m_tlast), 32'(r.last));
        if (m_tdata[5] != r.active)
          report_mismatch("active", 32'(m_tdata[5]), 32'(r.active));
        if (m_tdata[37:6] != r.remaining)
          report_mismatch("remaining", m_tdata[37:6], r.remaining);
        if (m_tdata[69:38] != r.elapsed) report_mismatch("elapsed", m_tdata[69:38], r.elapsed);
        if (m_tdata[101:70] != r.slice_length)
          report_mismatch("slice_length", m_tdata[101:70], r.slice_length);
        if (m_tdata[133:102] != r.rem_out)
          report_mismatch("rem_clock_out", m_tdata[133:102], r.rem_out);
        if (m_tdata[165:134] != r.total)
          report_mismatch("total_clock", m_tdata[165:134], r.total);
        if (r.fired_valid) fired_seen++;
      end
      checked++;
    end
  end

  // receiver stall pattern, changing mode with bits 9:8 of the cycle counter
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst) m_tready <= 1'b0;
    else case (cycle[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= (cycle[2:0] != 3'd0);
      default: m_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_reports.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] cmd, logic [4:0] id, logic [31:0] ec, logic hh,
                              logic [31:0] rem);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, rem, hh, ec, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_queue(cmd, id, ec, hh, rem);
    requests++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_max_slice(logic [30:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    q_max_slice = {1'b0, value};
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_clock();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return -$urandom_range(0, 500);
      2: return $urandom_range(0, 20);
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  function automatic logic [31:0] pick_rem();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return -$urandom_range(0, 100);
      default: return $urandom_range(0, (q_slice > 0 && q_slice < 4000) ? q_slice : 100);
    endcase
  endfunction

  task automatic test_directed;
    send_request(tevq_pkg::CMD_QUERY, 5'd0, 32'd0, 1'b0, 32'd0);
    send_request(tevq_pkg::CMD_PROGRESS, 5'd0, 32'd0, 1'b0, 32'd0);
    send_request(tevq_pkg::CMD_SET_ABS, 5'd0, 32'd100, 1'b1, 32'd0);
    send_request(tevq_pkg::CMD_SET_ABS, 5'd31, 32'd100, 1'b1, 32'd50);
    send_request(tevq_pkg::CMD_SET_REL, 5'd7, 32'd40, 1'b1, 32'd10);
    send_request(tevq_pkg::CMD_SET_ABS, 5'd9, 32'h7fffffff, 1'b0, 32'hffffffff);
    send_request(tevq_pkg::CMD_SET_ABS, 5'd10, 32'h80000000, 1'b1, 32'h80000000);
    send_request(tevq_pkg::CMD_QUERY, 5'd31, 32'd0, 1'b0, 32'd5);
    send_request(tevq_pkg::CMD_QUERY, 5'd3, 32'd0, 1'b0, 32'd5);
    send_request(tevq_pkg::CMD_CANCEL, 5'd3, 32'd0, 1'b0, 32'd5);
    send_request(tevq_pkg::CMD_CANCEL, 5'd9, 32'd0, 1'b0, 32'd5);
    send_request(tevq_pkg::CMD_FORCE_END, 5'd0, 32'd0, 1'b0, 32'd0);
    send_request(tevq_pkg::CMD_FORCE_END, 5'd0, 32'd0, 1'b0, 32'hfffffff0);
    send_request(tevq_pkg::CMD_FORCE_END, 5'd0, 32'd0, 1'b0, 32'd3);
    send_request(CMD_UNUSED, 5'd31, 32'hffffffff, 1'b1, 32'hffffffff);
    send_request(tevq_pkg::CMD_PROGRESS, 5'd0, 32'd0, 1'b0, 32'd0);
    send_request(tevq_pkg::CMD_REPEAT, 5'd0, 32'd0, 1'b0, 32'd0);
    send_request(tevq_pkg::CMD_REPEAT, 5'd20, 32'd0, 1'b0, 32'd0);
    send_request(tevq_pkg::CMD_PROGRESS, 5'd0, 32'd0, 1'b0, 32'h7fffffff);
    send_request(tevq_pkg::CMD_PROGRESS, 5'd0, 32'd0, 1'b0, 32'd0);
    send_request(tevq_pkg::CMD_QUERY, 5'd0, 32'd0, 1'b0, 32'd0);
  endtask

  task automatic test_full_list;
    for (int i = 0; i < tevq_pkg::MAX_EVENTS; i++)
      send_request(tevq_pkg::CMD_SET_ABS, i[4:0], 32'd5 + 32'(i % 3), 1'b1, 32'd0);
    send_request(tevq_pkg::CMD_SET_REL, 5'd17, 32'd1, 1'b1, 32'd0);
    send_request(tevq_pkg::CMD_QUERY, 5'd17, 32'd0, 1'b0, 32'd0);
    send_request(tevq_pkg::CMD_PROGRESS, 5'd0, 32'd0, 1'b0, 32'd0);
    send_request(tevq_pkg::CMD_PROGRESS, 5'd0, 32'd0, 1'b0, 32'd0);
  endtask

  task automatic test_random(int count);
    logic [2:0] cmd;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = tevq_pkg::CMD_SET_ABS;
      else if (pick < 40) cmd = tevq_pkg::CMD_SET_REL;
      else if (pick < 50) cmd = tevq_pkg::CMD_CANCEL;
      else if (pick < 58) cmd = tevq_pkg::CMD_REPEAT;
      else if (pick < 82) cmd = tevq_pkg::CMD_PROGRESS;
      else if (pick < 93) cmd = tevq_pkg::CMD_QUERY;
      else if (pick < 98) cmd = tevq_pkg::CMD_FORCE_END;
      else cmd = CMD_UNUSED;
      send_request(cmd, 5'($urandom_range(0, 31)), pick_clock(), $urandom_range(0, 3) != 0,
                   pick_rem());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_max_slice(31'd1);
    test_full_list();
    write_max_slice(31'h7fffffff);
    test_random(60);
    write_max_slice(31'd200);
    test_random(70);
    write_max_slice(31'd1024);
    test_random(70);
    write_max_slice(31'($urandom_range(1, 5000)));
    test_random(15);
    drain();
    $display("%0d requests, %0d results checked, %0d expiry reports, max_slice 1 to 2^31-1",
             requests, checked, fired_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
